@@ rtl/core/brr_pkg.sv @@
// brr_pkg: shared constants and helpers for the bf16 row rescale unit
// no dependencies
`timescale 1ns / 1ps
package brr_pkg;
  localparam int ROWS = 16;
  localparam int COLS = 64;
  localparam int ROW_W = 4;
  localparam int COL_W = 6;
  localparam int ADDR_W = 10;
  localparam int COLS_LOG2 = $clog2(COLS);
  localparam int TCOLS_LOG2 = $clog2(COLS / 8);

  localparam logic LAYOUT_ROW_MAJOR = 1'b0;
  localparam logic LAYOUT_MICROTILE = 1'b1;

  localparam logic [31:0] FP32_QNAN = 32'h7FC0_0000;
  localparam logic [7:0] EXP_MAX = 8'hFF;

  // count of leading zeros in a 24-bit significand
  function automatic logic [4:0] lzc24(input logic [23:0] m);
    logic [4:0] n;
    logic found;
    n = 5'd24;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && m[i]) begin
        n = 5'(23 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction
endpackage

@@ rtl/core/brr_stream_if.sv @@
// brr_stream_if: valid/ready channels for input elements, results and layout configuration
// depends on nothing
`timescale 1ns / 1ps
interface brr_in_if;
  logic valid;
  logic ready;
  logic [3:0] row;
  logic [5:0] col;
  logic [15:0] value;
  logic [31:0] scale;
  modport source(output valid, row, col, value, scale, input ready);
  modport sink(input valid, row, col, value, scale, output ready);
endinterface

interface brr_out_if;
  logic valid;
  logic ready;
  logic [9:0] address;
  logic [15:0] result;
  modport source(output valid, address, result, input ready);
  modport sink(input valid, address, result, output ready);
endinterface

interface brr_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

@@ rtl/core/bf16_row_rescale_unit.sv @@
// bf16_row_rescale_unit: top level, input register, datapath, output register
// depends on brr_pkg, brr_stream_if, brr_addr, brr_mul
`timescale 1ns / 1ps
// One bf16 element per cycle is scaled by its row's fp32 factor (ieee single
// multiply, nearest even, subnormals kept), rounded to bf16 by adding 0x7fff
// plus the kept lsb, and paired with its store address (row-major, or 4x8
// microtiled when layout_mode is set). Each item passes one input register,
// the combinational multiply and address logic, then one result register.
// Throughput is one item per cycle; ready drops only when both registers hold
// items and the output is stalled. The configuration channel is always ready
// and should only be written when idle.
module bf16_row_rescale_unit
  import brr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  brr_cfg_if.sink    cfg,
  brr_in_if.sink     in_ch,
  brr_out_if.source  out_ch
);
  logic              layout_mode;
  // input register
  logic              s1_valid;
  logic [ROW_W-1:0]  s1_row;
  logic [COL_W-1:0]  s1_col;
  logic [15:0]       s1_value;
  logic [31:0]       s1_scale;
  // datapath outputs
  logic [ADDR_W-1:0] d_address;
  logic [15:0]       d_result;
  // result register
  logic              s2_valid;
  logic [ADDR_W-1:0] s2_address;
  logic [15:0]       s2_result;
  logic              s2_load;
  logic              s1_load;

  assign cfg.ready = 1'b1;
  assign s2_load = s1_valid && (!s2_valid || out_ch.ready);
  assign s1_load = in_ch.valid && in_ch.ready;
  // input stage frees when empty or passing its item on
  assign in_ch.ready = !s1_valid || s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      layout_mode <= LAYOUT_ROW_MAJOR;
    end else if (cfg.valid) begin
      layout_mode <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
    if (s1_load) begin
      s1_row   <= in_ch.row;
      s1_col   <= in_ch.col;
      s1_value <= in_ch.value;
      s1_scale <= in_ch.scale;
    end
  end

  brr_addr u_addr (
    .layout_mode(layout_mode),
    .row(s1_row),
    .col(s1_col),
    .address(d_address)
  );

  brr_mul u_mul (
    .value(s1_value),
    .scale(s1_scale),
    .result(d_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= 1'b1;
    end else if (out_ch.ready) begin
      s2_valid <= 1'b0;
    end
    if (s2_load) begin
      s2_address <= d_address;
      s2_result  <= d_result;
    end
  end

  assign out_ch.valid   = s2_valid;
  assign out_ch.address = s2_address;
  assign out_ch.result  = s2_result;
endmodule

@@ rtl/core/brr_addr.sv @@
// brr_addr: element store address under row-major or 4x8 microtiled layout
// depends on brr_pkg
`timescale 1ns / 1ps
module brr_addr
  import brr_pkg::*;
(
  input  logic              layout_mode,
  input  logic [ROW_W-1:0]  row,
  input  logic [COL_W-1:0]  col,
  output logic [ADDR_W-1:0] address
);
  logic [31:0] rm;
  logic [31:0] mt;
  always_comb begin
    rm = (32'(row) << COLS_LOG2) + 32'(col);
    mt = ((((32'(row) >> 2) << TCOLS_LOG2) + (32'(col) >> 3)) << 5)
       + (32'(row[1:0]) << 3) + 32'(col[2:0]);
    address = (layout_mode == LAYOUT_MICROTILE) ? mt[ADDR_W-1:0] : rm[ADDR_W-1:0];
  end
endmodule

@@ rtl/core/brr_mul.sv @@
// brr_mul: fp32 multiply (nearest even, subnormals kept) then bf16 rounding
// depends on brr_pkg
`timescale 1ns / 1ps
module brr_mul
  import brr_pkg::*;
(
  input  logic [15:0] value,
  input  logic [31:0] scale,
  output logic [15:0] result
);
  logic [31:0] a;
  logic        sgn;
  logic [7:0]  ea, eb;
  logic [22:0] ma, mb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [4:0]  lz;
  logic [23:0] sa, sb;
  logic signed [10:0] xa, xb, e;
  logic [47:0] p;
  logic [5:0]  sh;
  logic [47:0] q, rem, half, mask;
  logic [31:0] prod, tmp;

  always_comb begin
    a = {value, 16'h0000};
    sgn = a[31] ^ scale[31];
    ea = a[30:23];
    eb = scale[30:23];
    ma = a[22:0];
    mb = scale[22:0];
    a_nan = (ea == EXP_MAX) && (ma != 0);
    b_nan = (eb == EXP_MAX) && (mb != 0);
    a_inf = (ea == EXP_MAX) && (ma == 0);
    b_inf = (eb == EXP_MAX) && (mb == 0);
    a_zero = a[30:0] == 0;
    b_zero = scale[30:0] == 0;
    lz = 5'd0;
    // bf16 input has only 7 fraction bits: subnormal shift is small
    if (ea == 0) begin
      lz = lzc24({1'b0, ma});
      sa = {1'b0, ma} << lz;
      xa = 11'sd1 - 11'(lz);
    end else begin
      sa = {1'b1, ma};
      xa = 11'(ea);
    end
    if (eb == 0) begin
      lz = lzc24({1'b0, mb});
      sb = {1'b0, mb} << lz;
      xb = 11'sd1 - 11'(lz);
    end else begin
      sb = {1'b1, mb};
      xb = 11'(eb);
    end
    // 24 x 24 multiply; value significand has 8 significant bits
    p = 48'(sa) * 48'(sb);
    e = xa + xb - 11'sd127;
    if (p[47]) e = e + 11'sd1;
    else p = p << 1;
    sh = 6'd24;
    if (e < 11'sd1) begin
      sh = (11'sd25 - e > 11'sd63) ? 6'd63 : 6'(11'sd25 - e);
    end
    mask = (48'd1 << sh) - 48'd1;
    q = p >> sh;
    rem = p & mask;
    half = 48'd1 << (sh - 6'd1);
    if (rem > half || (rem == half && q[0])) q = q + 48'd1;
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) prod = FP32_QNAN;
    else if (a_inf || b_inf) prod = {sgn, 31'h7F80_0000};
    else if (a_zero || b_zero) prod = {sgn, 31'h0};
    else if (e >= 11'sd255) prod = {sgn, 31'h7F80_0000};
    else if (e >= 11'sd1) prod = {sgn, 31'((32'(e - 11'sd1) << 23) + q[31:0])};
    else if (11'sd1 - e > 11'sd38) prod = {sgn, 31'h0};
    else prod = {sgn, q[30:0]};
    tmp = prod + 32'h7FFF + 32'(prod[16]);
    result = tmp[31:16];
  end
endmodule

@@ sim/bf16_row_rescale_unit_checker.sv @@
// bf16_row_rescale_unit_checker: watches the input and output channels, predicts each result
// depends on brr_pkg and brr_stream_if
`timescale 1ns / 1ps
module bf16_row_rescale_unit_checker
  import brr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  brr_cfg_if.sink   cfg,
  brr_in_if.sink    in_ch,
  brr_out_if.sink   out_ch,
  output int        fail_count,
  output int        pending_count,
  output int        result_count
);
  typedef struct packed {
    logic [9:0]  address;
    logic [15:0] result;
  } scaled_elem_t;

  scaled_elem_t expected_elems[$];
  logic         layout_sel;

  // fp32 multiply, nearest even, subnormals kept
  function automatic logic [31:0] fp32_product(input logic [31:0] a, input logic [31:0] b);
    logic        sgn;
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    int          xa, xb, e, sh;
    logic [23:0] sa, sb;
    logic [47:0] p;
    logic [63:0] rem, half;
    logic [31:0] q;
    sgn = a[31] ^ b[31];
    ea = a[30:23]; eb = b[30:23];
    fa = a[22:0];  fb = b[22:0];
    a_nan = (ea == EXP_MAX) && (fa != 0);
    b_nan = (eb == EXP_MAX) && (fb != 0);
    a_inf = (ea == EXP_MAX) && (fa == 0);
    b_inf = (eb == EXP_MAX) && (fb == 0);
    a_zero = a[30:0] == 0;
    b_zero = b[30:0] == 0;
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) return FP32_QNAN;
    if (a_inf || b_inf) return {sgn, 31'h7F80_0000};
    if (a_zero || b_zero) return {sgn, 31'd0};
    xa = (ea == 0) ? 1 : ea;
    sa = (ea == 0) ? {1'b0, fa} : {1'b1, fa};
    while (!sa[23]) begin sa = sa << 1; xa--; end
    xb = (eb == 0) ? 1 : eb;
    sb = (eb == 0) ? {1'b0, fb} : {1'b1, fb};
    while (!sb[23]) begin sb = sb << 1; xb--; end
    p = sa * sb;
    e = xa + xb - 127;
    if (p[47]) e++;
    else p = p << 1;
    if (e >= 255) return {sgn, 31'h7F80_0000};
    if (e >= 1) sh = 24;
    else begin
      if (1 - e > 38) return {sgn, 31'd0};
      sh = 25 - e;
    end
    q = 32'(p >> sh);
    rem = 64'(p) & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q++;
    if (e >= 1) return {sgn, 31'((32'(e - 1) << 23) + q)};
    return {sgn, q[30:0]};
  endfunction

  function automatic scaled_elem_t rescale_elem(input logic [3:0] row, input logic [5:0] col,
                                                input logic [15:0] value,
                                                input logic [31:0] scale,
                                                input logic mode);
    scaled_elem_t r;
    logic [31:0]  prod, rounded;
    int           a;
    if (mode == LAYOUT_MICROTILE)
      a = ((row / 4) * (COLS / 8) + col / 8) * 32 + (row % 4) * 8 + col % 8;
    else
      a = row * COLS + col;
    prod = fp32_product({value, 16'd0}, scale);
    rounded = prod + 32'h7FFF + prod[16];
    r.address = 10'(a);
    r.result = rounded[31:16];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    scaled_elem_t want;
    if (rst) begin
      layout_sel <= LAYOUT_ROW_MAJOR;
      expected_elems.delete();
      fail_count = 0;
      result_count <= 0;
    end else begin
      if (cfg.valid && cfg.ready) layout_sel <= cfg.data;
      if (in_ch.valid && in_ch.ready)
        expected_elems.push_back(rescale_elem(in_ch.row, in_ch.col, in_ch.value,
                                              in_ch.scale, layout_sel));
      if (out_ch.valid && out_ch.ready) begin
        result_count <= result_count + 1;
        if (expected_elems.size() == 0) begin
          $display("unexpected item: address %h result %h", out_ch.address, out_ch.result);
          fail_count++;
        end else begin
          want = expected_elems.pop_front();
          if (out_ch.address != want.address)
            report_mismatch("address", 16'(out_ch.address), 16'(want.address));
          if (out_ch.result != want.result)
            report_mismatch("result", out_ch.result, want.result);
        end
      end
    end
  end

  assign pending_count = expected_elems.size();
endmodule

@@ sim/bf16_row_rescale_unit_tb.sv @@
// bf16_row_rescale_unit_tb: stimulus, back-pressure and verdict for the row rescale unit
// depends on brr_pkg, brr_stream_if, the unit and bf16_row_rescale_unit_checker
`timescale 1ns / 1ps
module bf16_row_rescale_unit_tb;
  import brr_pkg::*;

  localparam int RANDOM_ITEMS = 1450;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;

  logic clk;
  logic rst;
  int   cycle_count = 0;
  int   fail_count, pending_count, result_count;
  bit   quiet_phase;     // no idling on either side
  bit   hold_off;        // long receiver stall
  int   directed_count;

  brr_cfg_if cfg();
  brr_in_if  in_ch();
  brr_out_if out_ch();

  bf16_row_rescale_unit u_top (.clk(clk), .rst(rst), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch));

  bf16_row_rescale_unit_checker u_checker (
    .clk(clk), .rst(rst), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: random stalls, a quiet stretch, and one long hold-off
  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else if (hold_off) out_ch.ready <= 1'b0;
    else if (quiet_phase) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(99) >= 14);
  end

  // hold-off counted in its own process
  initial begin
    hold_off = 1'b0;
    wait (directed_count == 300);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off = 1'b0;
  end

  // pick a scale from interesting fp32 classes
  function automatic logic [31:0] pick_scale();
    logic [31:0] s;
    s = $urandom;
    case ($urandom_range(9))
      0: s[30:23] = 8'h00;                      // subnormal or zero
      1: s[30:23] = 8'hFF;                      // inf or nan
      2: s[30:0] = 31'd0;                       // signed zero
      3: s[30:23] = 8'(8'd1 + $urandom_range(3)); // near underflow
      4: s[30:23] = 8'(8'd250 + $urandom_range(4)); // near overflow
      default: s[30:23] = 8'(8'd110 + $urandom_range(30));
    endcase
    return s;
  endfunction

  function automatic logic [15:0] pick_value();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(9))
      0: v[14:7] = 8'h00;
      1: v[14:7] = 8'hFF;
      2: v[14:0] = 15'd0;
      3: v[14:7] = 8'(8'd1 + $urandom_range(3));
      4: v[14:7] = 8'(8'd250 + $urandom_range(4));
      default: ;
    endcase
    return v;
  endfunction

  // send one item, idling first at random; valid stays high across back-to-back items
  task automatic send_elem(input logic [3:0] row, input logic [5:0] col,
                           input logic [15:0] value, input logic [31:0] scale);
    if (!quiet_phase && !hold_off && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.row <= row;
    in_ch.col <= col;
    in_ch.value <= value;
    in_ch.scale <= scale;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    directed_count++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_layout(input logic mode);
    cfg.valid <= 1'b1;
    cfg.data <= mode;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic send_directed();
    send_elem(4'd0, 6'd0, 16'h3F80, 32'h3F80_0000);     // one times one
    send_elem(4'd15, 6'd63, 16'hFFFF, 32'hFFFF_FFFF);   // extremes, nan
    send_elem(4'd3, 6'd7, 16'h7F80, 32'h0000_0000);     // inf times zero
    send_elem(4'd4, 6'd8, 16'hFF80, 32'h4000_0000);     // negative inf
    send_elem(4'd5, 6'd9, 16'h8000, 32'h3F00_0000);     // negative zero
    send_elem(4'd1, 6'd1, 16'h0001, 32'h3F80_0000);     // bf16 subnormal
    send_elem(4'd2, 6'd2, 16'h0080, 32'h0000_0001);     // deep underflow
    send_elem(4'd6, 6'd33, 16'h7F7F, 32'h7F7F_FFFF);    // overflow
    send_elem(4'd7, 6'd40, 16'h3F81, 32'h3F80_8000);    // rounding just above a tie
    send_elem(4'd8, 6'd55, 16'h00FF, 32'h3F00_0001);    // product goes subnormal
    send_elem(4'd9, 6'd62, 16'h7FC1, 32'h3F80_0000);    // nan value
    send_elem(4'd12, 6'd31, 16'h4049, 32'h7F80_0000);   // finite times inf
    send_elem(4'd13, 6'd15, 16'h0000, 32'h7F80_0000);   // zero times inf
    send_elem(4'd14, 6'd48, 16'h3F80, 32'h0080_0000);   // smallest normal scale
  endtask

  task automatic send_random(input int count);
    repeat (count)
      send_elem(4'($urandom), 6'($urandom), pick_value(), pick_scale());
  endtask

  initial begin
    rst = 1'b1;
    directed_count = 0;
    quiet_phase = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.row = '0;
    in_ch.col = '0;
    in_ch.value = '0;
    in_ch.scale = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // row-major directed items, then microtiled
    write_layout(LAYOUT_ROW_MAJOR);
    send_directed();
    drain_results();
    write_layout(LAYOUT_MICROTILE);
    send_directed();
    drain_results();

    // random phases across both layouts, one without any idling
    send_random(RANDOM_ITEMS / 3);
    drain_results();
    write_layout(LAYOUT_ROW_MAJOR);
    quiet_phase = 1'b1;
    send_random(RANDOM_ITEMS / 3);
    drain_results();
    quiet_phase = 1'b0;
    write_layout(LAYOUT_MICROTILE);
    send_random(RANDOM_ITEMS / 3);
    drain_results();
    repeat (10) @(negedge clk);

    $display("covered %0d results over both layouts, fp32 special classes and stalls",
             result_count);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
